FILE: rtl/mdfe_pkg.sv
package mdfe_pkg;

  localparam int MAX_ROWS = 128;
  localparam int MAX_COLS = 128;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CELL_W = ROW_W + COL_W;
  localparam int CFG_W = 8;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [2:0] MOVE_DOWN = 3'd0;
  localparam logic [2:0] MOVE_UP = 3'd1;
  localparam logic [2:0] MOVE_RIGHT = 3'd2;
  localparam logic [2:0] MOVE_LEFT = 3'd3;
  localparam logic [2:0] MOVE_STAY = 3'd4;

  typedef struct packed {
    logic cmd;
    logic [6:0] row;
    logic [6:0] col;
    logic wall_down;
    logic wall_up;
    logic wall_right;
    logic wall_left;
  } item_t;

  typedef struct packed {
    logic [2:0] move;
    logic backtrack;
  } result_t;

  typedef struct packed {
    logic vis_re;
    logic [ROW_W-1:0] vis_raddr;
    logic vis_we;
    logic [ROW_W-1:0] vis_waddr;
    logic [MAX_COLS-1:0] vis_wdata;
    logic pred_re;
    logic [CELL_W-1:0] pred_raddr;
    logic pred_we;
    logic [CELL_W-1:0] pred_waddr;
    logic [CELL_W-1:0] pred_wdata;
  } map_req_t;

endpackage

FILE: rtl/mdfe_maps.sv
module mdfe_maps (
  input  logic                             clk,
  input  mdfe_pkg::map_req_t               req,
  output logic [mdfe_pkg::MAX_COLS-1:0]    vis_rdata,
  output logic [mdfe_pkg::CELL_W-1:0]      pred_rdata
);
  import mdfe_pkg::*;

  logic [MAX_COLS-1:0] vis_mem [MAX_ROWS];
  logic [CELL_W-1:0] pred_mem [MAX_ROWS*MAX_COLS];

  always_ff @(posedge clk) begin
    if (req.vis_we) begin
      vis_mem[req.vis_waddr] <= req.vis_wdata;
    end
    if (req.vis_re) begin
      vis_rdata <= vis_mem[req.vis_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.pred_we) begin
      pred_mem[req.pred_waddr] <= req.pred_wdata;
    end
    if (req.pred_re) begin
      pred_rdata <= pred_mem[req.pred_raddr];
    end
  end

endmodule

FILE: rtl/maze_depth_first_explorer_core.sv
// A step transaction is accepted when start is high and busy is low; it then runs through
// the S_CUR, S_DOWN and S_UP states, its result strobes on done for one cycle, registered
// from S_UP, and no new transaction is accepted until busy is low again. The receiver cannot
// stall. A clear transaction gives no result and keeps busy high while the visited map is
// swept one row per cycle. After reset, busy stays high while the predecessor map is zeroed
// one entry per cycle and the visited map with it; configuration writes are taken then.
module maze_depth_first_explorer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  mdfe_pkg::item_t                 item,
  output logic                            done,
  output mdfe_pkg::result_t               result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mdfe_pkg::APB_AW-1:0]     paddr,
  input  logic [mdfe_pkg::APB_DW-1:0]     pwdata,
  output logic [mdfe_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import mdfe_pkg::*;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CUR   = 6'b000100,
    S_DOWN  = 6'b001000,
    S_UP    = 6'b010000,
    S_CLEAR = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [CELL_W-1:0] cnt, cnt_next;
  logic [CFG_W-1:0] rows, cols;
  item_t cur;
  logic [MAX_COLS-1:0] cur_row;
  logic down_vis;
  map_req_t req;
  logic [MAX_COLS-1:0] vis_rdata;
  logic [CELL_W-1:0] pred_rdata;
  logic accept;
  logic cfg_write;

  logic [CFG_W-1:0] r_ext, c_ext, down_r, up_r, right_c, left_c;
  logic in_down, in_up, in_right, in_left;
  logic ok_down, ok_up, ok_right, ok_left;
  logic up_vis;
  logic [ROW_W-1:0] pr;
  logic [COL_W-1:0] pc;
  result_t res_next;
  logic fwd;
  logic [CELL_W-1:0] fwd_addr;

  mdfe_maps u_maps (
    .clk        (clk),
    .req        (req),
    .vis_rdata  (vis_rdata),
    .pred_rdata (pred_rdata)
  );

  assign pready = 1'b1;
  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= CFG_W'(MAX_ROWS);
      cols <= CFG_W'(MAX_COLS);
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_ROWS: rows <= pwdata[CFG_W-1:0];
        REG_COLS: cols <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROWS: prdata = APB_DW'(rows);
      REG_COLS: prdata = APB_DW'(cols);
      default:  prdata = '0;
    endcase
  end

  assign r_ext = CFG_W'(cur.row);
  assign c_ext = CFG_W'(cur.col);
  assign down_r = r_ext + CFG_W'(1);
  assign up_r = r_ext - CFG_W'(1);
  assign right_c = c_ext + CFG_W'(1);
  assign left_c = c_ext - CFG_W'(1);

  assign in_down = (down_r < rows) && (down_r < CFG_W'(MAX_ROWS)) && (c_ext < cols);
  assign in_up = (cur.row != '0) && (up_r < rows) && (c_ext < cols);
  assign in_right = (right_c < cols) && (right_c < CFG_W'(MAX_COLS)) && (r_ext < rows);
  assign in_left = (cur.col != '0) && (left_c < cols) && (r_ext < rows);

  assign up_vis = vis_rdata[cur.col];
  assign ok_down = in_down && !cur.wall_down && !down_vis;
  assign ok_up = in_up && !cur.wall_up && !up_vis;
  assign ok_right = in_right && !cur.wall_right && !cur_row[right_c[COL_W-1:0]];
  assign ok_left = in_left && !cur.wall_left && !cur_row[left_c[COL_W-1:0]];

  assign pr = pred_rdata[CELL_W-1:COL_W];
  assign pc = pred_rdata[COL_W-1:0];

  always_comb begin
    fwd = 1'b1;
    fwd_addr = {cur.row, cur.col};
    res_next.backtrack = 1'b0;
    if (ok_down) begin
      res_next.move = MOVE_DOWN;
      fwd_addr = {down_r[ROW_W-1:0], cur.col};
    end else if (ok_up) begin
      res_next.move = MOVE_UP;
      fwd_addr = {up_r[ROW_W-1:0], cur.col};
    end else if (ok_right) begin
      res_next.move = MOVE_RIGHT;
      fwd_addr = {cur.row, right_c[COL_W-1:0]};
    end else if (ok_left) begin
      res_next.move = MOVE_LEFT;
      fwd_addr = {cur.row, left_c[COL_W-1:0]};
    end else begin
      fwd = 1'b0;
      res_next.backtrack = 1'b1;
      if (cur.row < pr) begin
        res_next.move = MOVE_DOWN;
      end else if (cur.row > pr) begin
        res_next.move = MOVE_UP;
      end else if (cur.col < pc) begin
        res_next.move = MOVE_RIGHT;
      end else if (cur.col > pc) begin
        res_next.move = MOVE_LEFT;
      end else begin
        res_next.move = MOVE_STAY;
        res_next.backtrack = 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    req = '0;
    unique case (state)
      S_INIT: begin
        req.vis_we = 1'b1;
        req.vis_waddr = cnt[ROW_W-1:0];
        req.pred_we = 1'b1;
        req.pred_waddr = cnt;
        cnt_next = cnt + CELL_W'(1);
        if (cnt == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (item.cmd == CMD_CLEAR) begin
            state_next = S_CLEAR;
            cnt_next = '0;
          end else begin
            state_next = S_CUR;
            req.vis_re = 1'b1;
            req.vis_raddr = item.row;
            req.pred_re = 1'b1;
            req.pred_raddr = {item.row, item.col};
          end
        end
      end
      S_CUR: begin
        req.vis_we = 1'b1;
        req.vis_waddr = cur.row;
        req.vis_wdata = vis_rdata | (MAX_COLS'(1) << cur.col);
        req.vis_re = 1'b1;
        req.vis_raddr = down_r[ROW_W-1:0];
        state_next = S_DOWN;
      end
      S_DOWN: begin
        req.vis_re = 1'b1;
        req.vis_raddr = up_r[ROW_W-1:0];
        state_next = S_UP;
      end
      S_UP: begin
        req.pred_we = fwd;
        req.pred_waddr = fwd_addr;
        req.pred_wdata = {cur.row, cur.col};
        state_next = S_IDLE;
      end
      S_CLEAR: begin
        req.vis_we = 1'b1;
        req.vis_waddr = cnt[ROW_W-1:0];
        cnt_next = cnt + CELL_W'(1);
        if (cnt[ROW_W-1:0] == '1) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      done <= (state == S_UP);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
    if (state == S_CUR) begin
      cur_row <= vis_rdata;
    end
    if (state == S_DOWN) begin
      down_vis <= vis_rdata[cur.col];
    end
    if (state == S_UP) begin
      result <= res_next;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("Sequencer state is not one-hot.");

  a_step_result: assert property (@(posedge clk) disable iff (rst)
      (accept && item.cmd == CMD_STEP) |-> ##4 done)
    else $error("Step transaction did not produce a result on time.");

  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
      (accept && item.cmd == CMD_CLEAR) |=> ##1 !done)
    else $error("Clear transaction produced a result.");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
      done |-> $past(state == S_UP))
    else $error("Result strobe without a finished step.");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
      (state == S_IDLE) |-> (!req.vis_we && !req.pred_we))
    else $error("Map written while idle.");

endmodule
